// ===== hw/rtl/lzwe_pkg.sv =====
// Shared types, constants and the hash function of the LZW byte encoder.
package lzwe_pkg;

  localparam int DICT_ENTRIES  = 4096;
  localparam int CODE_W        = $clog2(DICT_ENTRIES);
  localparam int NFC_W         = CODE_W + 1;
  localparam int SLOT_W        = CODE_W;
  localparam int SLOTS         = 2 ** SLOT_W;
  localparam int EPOCH_W       = 8;
  localparam int OUT_W         = 12;
  localparam int FIRST_LEARNED = 256;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [NFC_W-1:0]   nfc_t;
  typedef logic [SLOT_W-1:0]  slot_idx_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  // One hash table slot: a learned pair and the code it was given.
  typedef struct packed {
    epoch_t     epoch;
    code_t      prefix;
    logic [7:0] sym;
    code_t      code;
  } slot_t;

  // One emitted result word.
  typedef struct packed {
    logic [OUT_W-1:0] code;
    logic             final_code;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_EMIT_MISS,
    ST_EMIT_LAST
  } state_t;

  function automatic slot_idx_t hash_slot(input code_t prefix, input logic [7:0] sym);
    hash_slot = slot_idx_t'(prefix) ^ (slot_idx_t'(sym) << (SLOT_W - 8));
  endfunction

endpackage

// ===== hw/rtl/lzwe_slot_ram.sv =====
// Single-port-write, registered-read memory holding the dictionary hash table.
module lzwe_slot_ram
  import lzwe_pkg::*;
(
  input  logic      clk,
  input  logic      wr_en,
  input  slot_idx_t wr_addr,
  input  slot_t     wr_data,
  input  slot_idx_t rd_addr,
  output slot_t     rd_data
);

  slot_t mem [SLOTS];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/lzwe_out_queue.sv =====
// Two-word output queue that decouples the encoder core from the result channel.
module lzwe_out_queue
  import lzwe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t    entry_r [2];
  logic       head_r, head_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;
  logic       tail;

  assign pop       = (count_r != 2'd0) && !out_stall;
  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = entry_r[head_r];
  assign tail      = head_r ^ count_r[0];

  always_comb begin
    head_nxt  = pop ? ~head_r : head_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[tail] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/lzw_byte_encoder.sv =====
// Top level of the LZW byte encoder: sequencer, phrase state and dictionary probing.
//
// Each accepted byte is looked up in a hash table that holds the learned pairs
// (phrase code, byte), probed linearly one slot at a time through a single
// memory read port and one shared compare. The first byte of a stream is stored
// as the phrase with no probe; any other byte passes a probe and a check for each
// slot it visits, then an emit step for each code it emits (up to two, each one
// waiting while the queue is full). Codes leave through a two-word queue, so new
// bytes are taken while results wait. Slots are tagged with a stream number;
// after reset, and after every 255th end of stream, a clearing pass over all
// 4096 slots sweeps the table while no byte is accepted.
module lzw_byte_encoder
  import lzwe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_stream,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_code,
  output logic             out_final_code
);

  state_t     state_r, state_nxt;
  code_t      phrase_r, phrase_nxt;
  logic       active_r, active_nxt;
  nfc_t       nfc_r, nfc_nxt;
  epoch_t     epoch_r, epoch_nxt;
  slot_idx_t  probe_r, probe_nxt;
  slot_idx_t  clear_r, clear_nxt;
  logic [7:0] sym_r, sym_nxt;
  logic       last_r, last_nxt;

  logic       wr_en;
  slot_idx_t  wr_addr;
  slot_t      wr_data;
  slot_t      rd_data;

  logic       push;
  result_t    push_data;
  logic       q_full;
  result_t    q_data;

  logic       accept;
  logic       slot_live;
  logic       slot_hit;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign slot_live = (rd_data.epoch == epoch_r);
  assign slot_hit  = slot_live && (rd_data.prefix == phrase_r) && (rd_data.sym == sym_r);

  always_comb begin
    state_nxt  = state_r;
    phrase_nxt = phrase_r;
    active_nxt = active_r;
    nfc_nxt    = nfc_r;
    epoch_nxt  = epoch_r;
    probe_nxt  = probe_r;
    clear_nxt  = clear_r;
    sym_nxt    = sym_r;
    last_nxt   = last_r;
    wr_en      = 1'b0;
    wr_addr    = probe_r;
    wr_data    = '{epoch: epoch_r, prefix: phrase_r, sym: sym_r, code: nfc_r[CODE_W-1:0]};
    push       = 1'b0;
    push_data  = '{code: OUT_W'(phrase_r), final_code: 1'b0};

    unique case (state_r)
      ST_CLEAR: begin
        // Stream number zero is never current, so zeroed slots read as empty.
        wr_en     = 1'b1;
        wr_addr   = clear_r;
        wr_data   = '0;
        clear_nxt = clear_r + 1'b1;
        if (clear_r == slot_idx_t'(SLOTS - 1)) begin
          epoch_nxt = epoch_t'(1);
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          sym_nxt  = in_data_byte;
          last_nxt = in_end_of_stream;
          if (!active_r) begin
            phrase_nxt = code_t'(in_data_byte);
            active_nxt = 1'b1;
            state_nxt  = in_end_of_stream ? ST_EMIT_LAST : ST_IDLE;
          end else begin
            probe_nxt = hash_slot(phrase_r, in_data_byte);
            state_nxt = ST_PROBE;
          end
        end
      end

      ST_PROBE: begin
        state_nxt = ST_CHECK;
      end

      ST_CHECK: begin
        if (slot_hit) begin
          phrase_nxt = rd_data.code;
          state_nxt  = last_r ? ST_EMIT_LAST : ST_IDLE;
        end else if (!slot_live) begin
          // Miss: learn the pair in this empty slot unless the dictionary is full.
          if (nfc_r < nfc_t'(DICT_ENTRIES)) begin
            wr_en   = 1'b1;
            nfc_nxt = nfc_r + 1'b1;
          end
          state_nxt = ST_EMIT_MISS;
        end else begin
          probe_nxt = probe_r + 1'b1;
          state_nxt = ST_PROBE;
        end
      end

      ST_EMIT_MISS: begin
        if (!q_full) begin
          push       = 1'b1;
          phrase_nxt = code_t'(sym_r);
          state_nxt  = last_r ? ST_EMIT_LAST : ST_IDLE;
        end
      end

      ST_EMIT_LAST: begin
        push_data.final_code = 1'b1;
        if (!q_full) begin
          push       = 1'b1;
          phrase_nxt = '0;
          active_nxt = 1'b0;
          nfc_nxt    = nfc_t'(FIRST_LEARNED);
          if (epoch_r == '1) begin
            clear_nxt = '0;
            state_nxt = ST_CLEAR;
          end else begin
            epoch_nxt = epoch_r + 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      phrase_r <= '0;
      active_r <= 1'b0;
      nfc_r    <= nfc_t'(FIRST_LEARNED);
      epoch_r  <= epoch_t'(1);
      clear_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      phrase_r <= phrase_nxt;
      active_r <= active_nxt;
      nfc_r    <= nfc_nxt;
      epoch_r  <= epoch_nxt;
      clear_r  <= clear_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    sym_r   <= sym_nxt;
    last_r  <= last_nxt;
  end

  lzwe_slot_ram u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (probe_r),
    .rd_data (rd_data)
  );

  lzwe_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (q_data)
  );

  assign out_code       = q_data.code;
  assign out_final_code = q_data.final_code;

endmodule
